// File: rtl/core/afrb_pkg.sv
// Shared types and constants of the audio frame ring buffer.
package afrb_pkg;

	// Field widths fixed by the item formats.
	localparam int OP_W = 3;
	localparam int FRAMES_W = 16;
	localparam int SAMPLE_W = 32;
	localparam int FILL_W = 11;
	localparam int CHANS_W = 4;
	localparam int COUNT_W = 32;
	localparam int CFG_DATA_W = 11;
	// Width for comparing frame positions against the capacity.
	localparam int CMP_W = 17;

	// Operation codes of an input item.
	typedef enum logic [OP_W-1:0] {
		OP_WRITE_BEGIN  = 3'd0,
		OP_WRITE_SAMPLE = 3'd1,
		OP_READ_BEGIN   = 3'd2,
		OP_READ_SAMPLE  = 3'd3,
		OP_RESYNC       = 3'd4,
		OP_RESET        = 3'd5
	} op_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_UNDERRUN = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_CAPACITY = 1'b0,
		REG_CHANNELS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [FRAMES_W-1:0] frame_count;
		logic [SAMPLE_W-1:0] sample_in;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [SAMPLE_W-1:0] sample_out;
		logic                block_last;
		logic [FILL_W-1:0]   fill_frames;
		logic [COUNT_W-1:0]  overflow_total;
		logic [COUNT_W-1:0]  underflow_total;
	} rsp_t;

	typedef struct packed {
		reg_idx_t              index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

endpackage

// File: rtl/core/afrb_if.sv
// Valid/ready channel interfaces of the audio frame ring buffer.
interface afrb_cmd_if;
	logic valid;
	logic ready;
	afrb_pkg::cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface afrb_rsp_if;
	logic valid;
	logic ready;
	afrb_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface afrb_cfg_if;
	logic valid;
	logic ready;
	afrb_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/audio_frame_ring_buffer.sv
// Top level of the audio frame ring buffer: block bookkeeping and sample memory.
// The ring takes one item per clock cycle while results are taken and answers
// each item with one result item in the cycle after acceptance. All samples
// live in a single synchronous memory of DEPTH_FRAMES * MAX_CHANNELS words with
// one access per cycle and registered read data; a write_sample item writes it
// and a read_sample item reads it, so the single memory port sets the rate of
// one sample per cycle. A result that is not taken holds the memory read
// register and stalls input. The memory needs no clearing pass after reset.
// Configuration writes are always taken and clear cursors, fill and open blocks;
// they belong between items, when no result is outstanding.
module audio_frame_ring_buffer #(
	parameter int DEPTH_FRAMES = 1024,
	parameter int MAX_CHANNELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	afrb_cmd_if.sink   cmd,
	afrb_rsp_if.source rsp,
	afrb_cfg_if.sink   cfg
);

	localparam int FW = $clog2(DEPTH_FRAMES);
	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int WORDS = DEPTH_FRAMES * MAX_CHANNELS;
	localparam int AW = $clog2(WORDS);
	localparam int FILL_W = afrb_pkg::FILL_W;
	localparam int CMP_W = afrb_pkg::CMP_W;
	localparam int CHANS_W = afrb_pkg::CHANS_W;
	localparam int FRAMES_W = afrb_pkg::FRAMES_W;
	localparam int SAMPLE_W = afrb_pkg::SAMPLE_W;
	localparam int COUNT_W = afrb_pkg::COUNT_W;

	// Configuration and ring state.
	logic [FILL_W-1:0]   cap_q;
	logic [CHANS_W-1:0]  chans_q;
	logic [FW-1:0]       wr_idx_q, rd_idx_q;
	logic [FILL_W-1:0]   fill_q, hist_q;
	logic                wopen_q, ropen_q;
	logic [FRAMES_W-1:0] wleft_q, rleft_q;
	logic [FILL_W-1:0]   wframes_q, rframes_q;
	logic [CHANS_W-1:0]  wchans_q, rchans_q;
	logic [FW-1:0]       wframe_q, rframe_q;
	logic [CW-1:0]       wchan_q, rchan_q;
	logic [COUNT_W-1:0]  ovf_q, unf_q;

	// Next-state values.
	logic [FW-1:0]       wr_idx_n, rd_idx_n;
	logic [FILL_W-1:0]   fill_n, hist_n;
	logic                wopen_n, ropen_n;
	logic [FRAMES_W-1:0] wleft_n, rleft_n;
	logic [FILL_W-1:0]   wframes_n, rframes_n;
	logic [CHANS_W-1:0]  wchans_n, rchans_n;
	logic [FW-1:0]       wframe_n, rframe_n;
	logic [CW-1:0]       wchan_n, rchan_n;
	logic [COUNT_W-1:0]  ovf_n, unf_n;
	afrb_pkg::status_t   status_n;
	logic                last_n;

	// Result stage.
	logic              v_s1;
	logic              rd_s1;
	afrb_pkg::status_t status_s1;
	logic              last_s1;

	// Sample memory and its single port.
	logic [SAMPLE_W-1:0] mem_q [WORDS];
	logic [SAMPLE_W-1:0] rdata_q;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_addr;

	logic accept;
	logic [CMP_W-1:0] n_ext;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = !v_s1 || rsp.ready;
	assign cfg.ready = 1'b1;
	assign n_ext = CMP_W'(cmd.data.frame_count);

	// Bookkeeping of one item against the current ring state.
	always_comb begin
		logic [CMP_W-1:0] fpos;
		logic [FILL_W:0]  sum;
		logic [FILL_W-1:0] tgt;
		logic             frame_end;
		wr_idx_n = wr_idx_q;
		rd_idx_n = rd_idx_q;
		fill_n = fill_q;
		hist_n = hist_q;
		wopen_n = wopen_q;
		ropen_n = ropen_q;
		wleft_n = wleft_q;
		rleft_n = rleft_q;
		wframes_n = wframes_q;
		rframes_n = rframes_q;
		wchans_n = wchans_q;
		rchans_n = rchans_q;
		wframe_n = wframe_q;
		rframe_n = rframe_q;
		wchan_n = wchan_q;
		rchan_n = rchan_q;
		ovf_n = ovf_q;
		unf_n = unf_q;
		status_n = afrb_pkg::ST_OK;
		last_n = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = AW'(AW'(wframe_q) * AW'(MAX_CHANNELS)) + AW'(wchan_q);
		fpos = '0;
		sum = '0;
		tgt = '0;
		frame_end = 1'b0;
		case (cmd.data.op)
			afrb_pkg::OP_WRITE_BEGIN: begin
				wopen_n = 1'b0;
				wleft_n = '0;
				if (CMP_W'(fill_q) + n_ext > CMP_W'(cap_q)) begin
					ovf_n = ovf_q + COUNT_W'(1);
					status_n = afrb_pkg::ST_OVERFLOW;
				end else if (cmd.data.frame_count == '0) begin
					last_n = 1'b1;
				end else begin
					wopen_n = 1'b1;
					wframes_n = FILL_W'(cmd.data.frame_count);
					wchans_n = chans_q;
					wframe_n = wr_idx_q;
					wchan_n = '0;
					wleft_n = cmd.data.frame_count;
				end
			end
			afrb_pkg::OP_WRITE_SAMPLE: begin
				if (!wopen_q) begin
					status_n = afrb_pkg::ST_IGNORED;
				end else begin
					// The memory is touched only by an accepted item.
					mem_we = accept;
					frame_end = (5'(wchan_q) + 5'd1) >= 5'(wchans_q);
					fpos = CMP_W'(wframe_q) + CMP_W'(1);
					if (frame_end) begin
						wchan_n = '0;
						wframe_n = (fpos >= CMP_W'(cap_q)) ? '0 : FW'(fpos);
						wleft_n = wleft_q - FRAMES_W'(1);
					end else begin
						wchan_n = wchan_q + CW'(1);
					end
					// Publish the block with its last sample.
					if (frame_end && wleft_q == FRAMES_W'(1)) begin
						wopen_n = 1'b0;
						wr_idx_n = wframe_n;
						fill_n = fill_q + wframes_q;
						sum = (FILL_W + 1)'(hist_q) + (FILL_W + 1)'(wframes_q);
						hist_n = (sum > (FILL_W + 1)'(cap_q)) ? cap_q : FILL_W'(sum);
						last_n = 1'b1;
					end
				end
			end
			afrb_pkg::OP_READ_BEGIN: begin
				ropen_n = 1'b0;
				rleft_n = '0;
				if (CMP_W'(fill_q) < n_ext) begin
					unf_n = unf_q + COUNT_W'(1);
					status_n = afrb_pkg::ST_UNDERRUN;
				end else if (cmd.data.frame_count == '0) begin
					last_n = 1'b1;
				end else begin
					ropen_n = 1'b1;
					rframes_n = FILL_W'(cmd.data.frame_count);
					rchans_n = chans_q;
					rframe_n = rd_idx_q;
					rchan_n = '0;
					rleft_n = cmd.data.frame_count;
				end
			end
			afrb_pkg::OP_READ_SAMPLE: begin
				if (!ropen_q) begin
					status_n = afrb_pkg::ST_IGNORED;
				end else begin
					// A waiting item must not disturb the held read register.
					mem_re = accept;
					mem_addr = AW'(AW'(rframe_q) * AW'(MAX_CHANNELS)) + AW'(rchan_q);
					frame_end = (5'(rchan_q) + 5'd1) >= 5'(rchans_q);
					fpos = CMP_W'(rframe_q) + CMP_W'(1);
					if (frame_end) begin
						rchan_n = '0;
						rframe_n = (fpos >= CMP_W'(cap_q)) ? '0 : FW'(fpos);
						rleft_n = rleft_q - FRAMES_W'(1);
					end else begin
						rchan_n = rchan_q + CW'(1);
					end
					// Release the block's frames with its last sample.
					if (frame_end && rleft_q == FRAMES_W'(1)) begin
						ropen_n = 1'b0;
						rd_idx_n = rframe_n;
						fill_n = (fill_q >= rframes_q) ? fill_q - rframes_q : '0;
						last_n = 1'b1;
					end
				end
			end
			afrb_pkg::OP_RESYNC: begin
				wopen_n = 1'b0;
				wleft_n = '0;
				ropen_n = 1'b0;
				rleft_n = '0;
				tgt = (n_ext > CMP_W'(hist_q)) ? hist_q : FILL_W'(cmd.data.frame_count);
				if (tgt > cap_q) begin
					tgt = cap_q;
				end
				// Read cursor goes tgt frames behind the write cursor, modulo capacity.
				sum = (FILL_W + 1)'(wr_idx_q) + (FILL_W + 1)'(cap_q) - (FILL_W + 1)'(tgt);
				if (sum >= (FILL_W + 1)'(cap_q)) begin
					sum = sum - (FILL_W + 1)'(cap_q);
				end
				rd_idx_n = FW'(sum);
				fill_n = tgt;
			end
			afrb_pkg::OP_RESET: begin
				wr_idx_n = '0;
				rd_idx_n = '0;
				fill_n = '0;
				hist_n = '0;
				wopen_n = 1'b0;
				ropen_n = 1'b0;
				wleft_n = '0;
				rleft_n = '0;
			end
			default: begin
				status_n = afrb_pkg::ST_IGNORED;
			end
		endcase
	end

	// Ring state registers; a configuration write clears the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= (DEPTH_FRAMES < 1024) ? FILL_W'(DEPTH_FRAMES) : FILL_W'(1024);
			chans_q <= (MAX_CHANNELS < 2) ? CHANS_W'(MAX_CHANNELS) : CHANS_W'(2);
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q <= '0;
			hist_q <= '0;
			wopen_q <= 1'b0;
			ropen_q <= 1'b0;
			wleft_q <= '0;
			rleft_q <= '0;
			wframes_q <= '0;
			rframes_q <= '0;
			wchans_q <= '0;
			rchans_q <= '0;
			wframe_q <= '0;
			rframe_q <= '0;
			wchan_q <= '0;
			rchan_q <= '0;
			ovf_q <= '0;
			unf_q <= '0;
		end else begin
			if (accept) begin
				wr_idx_q <= wr_idx_n;
				rd_idx_q <= rd_idx_n;
				fill_q <= fill_n;
				hist_q <= hist_n;
				wopen_q <= wopen_n;
				ropen_q <= ropen_n;
				wleft_q <= wleft_n;
				rleft_q <= rleft_n;
				wframes_q <= wframes_n;
				rframes_q <= rframes_n;
				wchans_q <= wchans_n;
				rchans_q <= rchans_n;
				wframe_q <= wframe_n;
				rframe_q <= rframe_n;
				wchan_q <= wchan_n;
				rchan_q <= rchan_n;
				ovf_q <= ovf_n;
				unf_q <= unf_n;
			end
			if (cfg.valid) begin
				unique case (cfg.data.index)
					afrb_pkg::REG_CAPACITY: begin
						if (cfg.data.value == '0) begin
							cap_q <= FILL_W'(1);
						end else if (CMP_W'(cfg.data.value) > CMP_W'(DEPTH_FRAMES)) begin
							cap_q <= FILL_W'(DEPTH_FRAMES);
						end else begin
							cap_q <= cfg.data.value;
						end
					end
					afrb_pkg::REG_CHANNELS: begin
						if (cfg.data.value[CHANS_W-1:0] == '0) begin
							chans_q <= CHANS_W'(1);
						end else if (5'(cfg.data.value[CHANS_W-1:0]) > 5'(MAX_CHANNELS)) begin
							chans_q <= CHANS_W'(MAX_CHANNELS);
						end else begin
							chans_q <= cfg.data.value[CHANS_W-1:0];
						end
					end
					default: begin
						chans_q <= chans_q;
					end
				endcase
				wr_idx_q <= '0;
				rd_idx_q <= '0;
				fill_q <= '0;
				hist_q <= '0;
				wopen_q <= 1'b0;
				ropen_q <= 1'b0;
				wleft_q <= '0;
				rleft_q <= '0;
			end
		end
	end

	// Sample memory. A sample is never written and read in the same cycle,
	// and a read in the cycle after a write already sees the stored word.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= cmd.data.sample_in;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	// Result stage; the read register holds while the result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			rd_s1 <= 1'b0;
			status_s1 <= afrb_pkg::ST_OK;
			last_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
			if (cmd.valid) begin
				rd_s1 <= mem_re;
				status_s1 <= status_n;
				last_s1 <= last_n;
			end
		end
	end

	// Fill changes only on acceptance or a configuration write, and the counters
	// only on acceptance, so they still match the waiting result.
	assign rsp.valid = v_s1;
	assign rsp.data.status = status_s1;
	assign rsp.data.sample_out = rd_s1 ? rdata_q : '0;
	assign rsp.data.block_last = last_s1;
	assign rsp.data.fill_frames = fill_q;
	assign rsp.data.overflow_total = ovf_q;
	assign rsp.data.underflow_total = unf_q;

`ifndef ASSERT_OFF
	// Published fill never exceeds the ring capacity.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill exceeds capacity");

	// The write cursor stays inside the ring.
	a_wr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(wr_idx_q) < cap_q)
		else $error("write cursor outside the ring");

	// An open write block always has frames left to fill.
	a_wopen_left: assert property (@(posedge clk) disable iff (!arst_n)
		wopen_q |-> (wleft_q != '0))
		else $error("open write block with no frames left");

	// A result carrying memory data always reports success.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rd_s1) |-> (status_s1 == afrb_pkg::ST_OK))
		else $error("memory read result with a failing status");
`endif

endmodule
